// ===== rtl/dtq_pkg.sv =====
package dtq_pkg;

    localparam int CAPACITY = 16;
    localparam int HANDLES  = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int HDL_W    = 4;
    localparam int TIME_W   = 48;
    localparam int TAG_W    = 32;
    localparam int DELAY_W  = 32;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_ABORT = 2'd2;

    localparam logic [2:0] KIND_ADDED    = 3'd0;
    localparam logic [2:0] KIND_FIRED    = 3'd1;
    localparam logic [2:0] KIND_ABORTED  = 3'd2;
    localparam logic [2:0] KIND_MISS     = 3'd3;
    localparam logic [2:0] KIND_FULL     = 3'd4;
    localparam logic [2:0] KIND_TICK_END = 3'd5;

    typedef struct packed {
        logic [1:0]         mode;
        logic [DELAY_W-1:0] delay_ms;
        logic [TAG_W-1:0]   task_tag;
        logic [HDL_W-1:0]   target_handle;
    } t_in;

    typedef struct packed {
        logic [2:0]       kind;
        logic [HDL_W-1:0] handle;
        logic [TAG_W-1:0] fired_tag;
        logic             last;
    } t_out;

    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [TAG_W-1:0]  tag;
        logic [HDL_W-1:0]  id;
    } t_entry;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             rm_en;
        logic [IDX_W-1:0] rm_pos;
        logic [IDX_W-1:0] rd_idx;
    } t_store_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_START,
        S_SCAN,
        S_ASCAN,
        S_OUT
    } t_state;

endpackage

// ===== rtl/dtq_store.sv =====
module dtq_store import dtq_pkg::*; (
    input  logic       i_clk,
    input  t_store_ctl i_ctl,
    input  t_entry     i_wr_data,
    output t_entry     o_rd_data
);

    t_entry r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_ctl.rm_en) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (IDX_W'(i) >= i_ctl.rm_pos) begin
                    r_mem[i] <= r_mem[i + 1];
                end
            end
        end else if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_idx] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[i_ctl.rd_idx];

endmodule

// ===== rtl/deadline_timer_queue.sv =====
// Deadline timer queue with 16 entries and 16 handles, time kept in 48-bit ticks.
// Requests are taken one at a time: o_in_stall stays high from acceptance until
// the last result of that request has been taken. An add or a missed abort goes
// from the execute state straight to the output handshake; a hit abort walks the
// age-ordered entry store one entry per cycle. A tick advances time by one, then
// for each fired entry and for the final check runs a serial minimum search
// through one due-time comparator. Results leave through an output register;
// removed entries are compacted in a single shift of all later entries.
module deadline_timer_queue import dtq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_state             r_state, n_state;
    logic [TIME_W-1:0]  r_now, n_now;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [HANDLES-1:0] r_ids, n_ids;
    logic [CNT_W-1:0]   r_idx, n_idx;

    t_in                r_req, n_req;
    t_out               r_out, n_out;
    logic [TIME_W-1:0]  r_best_due, n_best_due;
    logic [TAG_W-1:0]   r_best_tag, n_best_tag;
    logic [HDL_W-1:0]   r_best_id, n_best_id;
    logic [IDX_W-1:0]   r_best_pos, n_best_pos;

    t_store_ctl         ctl;
    t_entry             wr_data;
    t_entry             rd_data;
    logic [TIME_W-1:0]  sum;
    logic [TIME_W-1:0]  cmp_due;
    logic [HDL_W-1:0]   free_h;
    logic               scan_less;

    dtq_store u_store (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    assign sum = r_now + ((r_req.mode == MODE_TICK) ? TIME_W'(1)
                                                    : TIME_W'(r_req.delay_ms));
    assign cmp_due   = (r_idx < r_count) ? rd_data.due : r_now;
    assign scan_less = cmp_due < r_best_due;

    always_comb begin
        free_h = '0;
        for (int k = HANDLES - 1; k >= 0; k--) begin
            if (!r_ids[k]) begin
                free_h = HDL_W'(k);
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    always_comb begin
        n_state    = r_state;
        n_now      = r_now;
        n_count    = r_count;
        n_ids      = r_ids;
        n_idx      = r_idx;
        n_req      = r_req;
        n_out      = r_out;
        n_best_due = r_best_due;
        n_best_tag = r_best_tag;
        n_best_id  = r_best_id;
        n_best_pos = r_best_pos;
        ctl        = '0;
        ctl.rd_idx = r_idx[IDX_W-1:0];
        ctl.wr_idx = r_count[IDX_W-1:0];
        wr_data.due = sum;
        wr_data.tag = r_req.task_tag;
        wr_data.id  = free_h;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_req.mode)
                    MODE_TICK: begin
                        n_now   = sum;
                        n_state = S_START;
                    end
                    MODE_ADD: begin
                        n_state = S_OUT;
                        n_out   = '{kind: KIND_FULL, handle: '0, fired_tag: '0, last: 1'b1};
                        if (r_count < CNT_W'(CAPACITY) && !(&r_ids)) begin
                            ctl.wr_en = 1'b1;
                            n_count   = r_count + CNT_W'(1);
                            n_ids     = r_ids | (HANDLES'(1) << free_h);
                            n_out.kind   = KIND_ADDED;
                            n_out.handle = free_h;
                        end
                    end
                    MODE_ABORT: begin
                        if (r_ids[r_req.target_handle]) begin
                            n_idx   = '0;
                            n_state = S_ASCAN;
                        end else begin
                            n_out   = '{kind: KIND_MISS, handle: '0, fired_tag: '0, last: 1'b1};
                            n_state = S_OUT;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_START: begin
                ctl.rd_idx = '0;
                if (r_count == '0) begin
                    n_out   = '{kind: KIND_TICK_END, handle: '0, fired_tag: '0, last: 1'b1};
                    n_state = S_OUT;
                end else begin
                    n_best_due = rd_data.due;
                    n_best_tag = rd_data.tag;
                    n_best_id  = rd_data.id;
                    n_best_pos = '0;
                    n_idx      = CNT_W'(1);
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx < r_count) begin
                    if (scan_less) begin
                        n_best_due = rd_data.due;
                        n_best_tag = rd_data.tag;
                        n_best_id  = rd_data.id;
                        n_best_pos = r_idx[IDX_W-1:0];
                    end
                    n_idx = r_idx + CNT_W'(1);
                end else if (scan_less) begin
                    n_out   = '{kind: KIND_TICK_END, handle: '0, fired_tag: '0, last: 1'b1};
                    n_state = S_OUT;
                end else begin
                    ctl.rm_en  = 1'b1;
                    ctl.rm_pos = r_best_pos;
                    n_count    = r_count - CNT_W'(1);
                    n_ids      = r_ids & ~(HANDLES'(1) << r_best_id);
                    n_out      = '{kind: KIND_FIRED, handle: r_best_id,
                                   fired_tag: r_best_tag, last: 1'b0};
                    n_state    = S_OUT;
                end
            end
            S_ASCAN: begin
                if (r_idx >= r_count) begin
                    n_out   = '{kind: KIND_MISS, handle: '0, fired_tag: '0, last: 1'b1};
                    n_state = S_OUT;
                end else if (rd_data.id == r_req.target_handle) begin
                    ctl.rm_en  = 1'b1;
                    ctl.rm_pos = r_idx[IDX_W-1:0];
                    n_count    = r_count - CNT_W'(1);
                    n_ids      = r_ids & ~(HANDLES'(1) << r_req.target_handle);
                    n_out      = '{kind: KIND_ABORTED, handle: r_req.target_handle,
                                   fired_tag: '0, last: 1'b1};
                    n_state    = S_OUT;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = r_out.last ? S_IDLE : S_START;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_now   <= '0;
            r_count <= '0;
            r_ids   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_now   <= n_now;
            r_count <= n_count;
            r_ids   <= n_ids;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_out      <= n_out;
        r_best_due <= n_best_due;
        r_best_tag <= n_best_tag;
        r_best_id  <= n_best_id;
        r_best_pos <= n_best_pos;
    end

endmodule

// ===== rtl/dtq_check.sv =====
module dtq_check import dtq_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block not busy after taking a request");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request taken while a result is pending");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_TICK_END |-> o_out_data.last)
        else $error("tick end not marked last");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_FIRED |-> o_out_data.fired_tag == '0)
        else $error("nonzero tag on a result that is not a fire");

endmodule

bind deadline_timer_queue dtq_check u_dtq_check (.*);
